[design/qrm_pkg.sv]
// ----------------------------------------------------------------------------
// qrm_pkg
// Shared types and constants for the quaternion to rotation matrix block.
// ----------------------------------------------------------------------------
package qrm_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int NUM_ENT       = 9;
    localparam int NUM_PROD      = 10;
    // Width of the squared length (up to 2^32) and of a signed numerator.
    localparam int NORM_W        = 33;
    localparam int NUM_W         = 34;

    // Product slots.
    localparam int P_WW = 0;
    localparam int P_XX = 1;
    localparam int P_YY = 2;
    localparam int P_ZZ = 3;
    localparam int P_XY = 4;
    localparam int P_XZ = 5;
    localparam int P_YZ = 6;
    localparam int P_WX = 7;
    localparam int P_WY = 8;
    localparam int P_WZ = 9;

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } t_quat_req;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
    } t_mat_rsp;

endpackage

[design/qrm_front.sv]
// ----------------------------------------------------------------------------
// qrm_front
// Two stages: the ten products, then squared length and the nine numerators
// set up as dividends for the division chain.
// ----------------------------------------------------------------------------
module qrm_front #(
    parameter int FRAC_BITS = qrm_pkg::FRAC_BITS_DEF,
    parameter int DW        = FRAC_BITS + 34
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  qrm_pkg::t_quat_req         i_req,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [qrm_pkg::NORM_W-1:0] o_den,
    output logic                       o_zero,
    output logic [8:0]                 o_neg,
    output logic [8:0][DW-1:0]         o_rem
);
    logic                                           r_va, r_vb;
    logic signed [qrm_pkg::NUM_PROD-1:0][31:0]      r_p;
    logic signed [qrm_pkg::NUM_PROD-1:0][31:0]      n_p;
    logic [qrm_pkg::NORM_W-1:0]                     r_den;
    logic                                           r_zero;
    logic [8:0]                                     r_neg;
    logic [8:0][DW-1:0]                             r_rem;
    logic                                           en_a, en_b;
    logic signed [qrm_pkg::NUM_PROD-1:0][qrm_pkg::NUM_W-1:0] e;
    logic signed [qrm_pkg::NUM_W-1:0]               nn;
    logic signed [8:0][qrm_pkg::NUM_W-1:0]          num;
    logic [8:0]                                     n_neg;
    logic [8:0][DW-1:0]                             n_rem;
    logic [qrm_pkg::NUM_W-1:0]                      mag;

    assign en_b    = !r_vb || i_ready;
    assign en_a    = !r_va || en_b;
    assign o_ready = en_a;
    assign o_valid = r_vb;
    assign o_den   = r_den;
    assign o_zero  = r_zero;
    assign o_neg   = r_neg;
    assign o_rem   = r_rem;

    always_comb begin
        n_p[qrm_pkg::P_WW] = i_req.quat_w * i_req.quat_w;
        n_p[qrm_pkg::P_XX] = i_req.quat_x * i_req.quat_x;
        n_p[qrm_pkg::P_YY] = i_req.quat_y * i_req.quat_y;
        n_p[qrm_pkg::P_ZZ] = i_req.quat_z * i_req.quat_z;
        n_p[qrm_pkg::P_XY] = i_req.quat_x * i_req.quat_y;
        n_p[qrm_pkg::P_XZ] = i_req.quat_x * i_req.quat_z;
        n_p[qrm_pkg::P_YZ] = i_req.quat_y * i_req.quat_z;
        n_p[qrm_pkg::P_WX] = i_req.quat_w * i_req.quat_x;
        n_p[qrm_pkg::P_WY] = i_req.quat_w * i_req.quat_y;
        n_p[qrm_pkg::P_WZ] = i_req.quat_w * i_req.quat_z;
    end

    always_comb begin
        mag = '0;
        for (int k = 0; k < qrm_pkg::NUM_PROD; k++) begin
            e[k] = {{(qrm_pkg::NUM_W-32){r_p[k][31]}}, r_p[k]};
        end
        nn = e[qrm_pkg::P_WW] + e[qrm_pkg::P_XX] + e[qrm_pkg::P_YY] + e[qrm_pkg::P_ZZ];
        num[0] = nn - ((e[qrm_pkg::P_YY] + e[qrm_pkg::P_ZZ]) <<< 1);
        num[1] = (e[qrm_pkg::P_XY] - e[qrm_pkg::P_WZ]) <<< 1;
        num[2] = (e[qrm_pkg::P_XZ] + e[qrm_pkg::P_WY]) <<< 1;
        num[3] = (e[qrm_pkg::P_XY] + e[qrm_pkg::P_WZ]) <<< 1;
        num[4] = nn - ((e[qrm_pkg::P_XX] + e[qrm_pkg::P_ZZ]) <<< 1);
        num[5] = (e[qrm_pkg::P_YZ] - e[qrm_pkg::P_WX]) <<< 1;
        num[6] = (e[qrm_pkg::P_XZ] - e[qrm_pkg::P_WY]) <<< 1;
        num[7] = (e[qrm_pkg::P_YZ] + e[qrm_pkg::P_WX]) <<< 1;
        num[8] = nn - ((e[qrm_pkg::P_XX] + e[qrm_pkg::P_YY]) <<< 1);
        // Dividend is |num| * 2^(F+1) + n, divided later by 2n: round half away.
        for (int k = 0; k < 9; k++) begin
            n_neg[k] = num[k][qrm_pkg::NUM_W-1];
            mag      = n_neg[k] ? -num[k] : num[k];
            n_rem[k] = (DW'(mag) << (FRAC_BITS + 1)) + DW'(nn[qrm_pkg::NORM_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (en_a) r_va <= i_valid;
            if (en_b) r_vb <= r_va;
        end
        if (en_a && i_valid) r_p <= n_p;
        if (en_b && r_va) begin
            r_den  <= nn[qrm_pkg::NORM_W-1:0];
            r_zero <= (nn == '0);
            r_neg  <= n_neg;
            r_rem  <= n_rem;
        end
    end
endmodule

[design/qrm_cell.sv]
// ----------------------------------------------------------------------------
// qrm_cell
// One restoring division cell: settles quotient bit BIT for all nine lanes.
// ----------------------------------------------------------------------------
module qrm_cell #(
    parameter int FRAC_BITS = qrm_pkg::FRAC_BITS_DEF,
    parameter int DW        = FRAC_BITS + 34,
    parameter int QW        = FRAC_BITS + 1,
    parameter int BIT       = 0
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [qrm_pkg::NORM_W-1:0] i_den,
    input  logic                       i_zero,
    input  logic [8:0]                 i_neg,
    input  logic [8:0][DW-1:0]         i_rem,
    input  logic [8:0][QW-1:0]         i_q,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [qrm_pkg::NORM_W-1:0] o_den,
    output logic                       o_zero,
    output logic [8:0]                 o_neg,
    output logic [8:0][DW-1:0]         o_rem,
    output logic [8:0][QW-1:0]         o_q
);
    logic                       r_v;
    logic [qrm_pkg::NORM_W-1:0] r_den;
    logic                       r_zero;
    logic [8:0]                 r_neg;
    logic [8:0][DW-1:0]         r_rem, n_rem;
    logic [8:0][QW-1:0]         r_q, n_q;
    logic [DW-1:0]              dvs;
    logic [DW:0]                diff;
    logic                       en;

    assign en      = !r_v || i_ready;
    assign o_ready = en;
    assign o_valid = r_v;
    assign o_den   = r_den;
    assign o_zero  = r_zero;
    assign o_neg   = r_neg;
    assign o_rem   = r_rem;
    assign o_q     = r_q;
    assign dvs     = DW'(i_den) << (BIT + 1);

    always_comb begin
        diff = '0;
        for (int k = 0; k < 9; k++) begin
            diff     = {1'b0, i_rem[k]} - {1'b0, dvs};
            n_rem[k] = diff[DW] ? i_rem[k] : diff[DW-1:0];
            n_q[k]   = i_q[k];
            n_q[k][BIT] = !diff[DW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (en) begin
            r_v <= i_valid;
        end
        if (en && i_valid) begin
            r_den  <= i_den;
            r_zero <= i_zero;
            r_neg  <= i_neg;
            r_rem  <= n_rem;
            r_q    <= n_q;
        end
    end
endmodule

[design/qrm_back.sv]
// ----------------------------------------------------------------------------
// qrm_back
// Applies sign, saturates to 16 bits, substitutes identity for a zero input.
// ----------------------------------------------------------------------------
module qrm_back #(
    parameter int FRAC_BITS = qrm_pkg::FRAC_BITS_DEF,
    parameter int QW        = FRAC_BITS + 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_zero,
    input  logic [8:0]          i_neg,
    input  logic [8:0][QW-1:0]  i_q,
    output logic                o_valid,
    input  logic                i_ready,
    output qrm_pkg::t_mat_rsp   o_rsp
);
    localparam logic signed [15:0] ONE =
        (FRAC_BITS >= 15) ? 16'sd32767 : 16'(1 << FRAC_BITS);

    logic                     r_v;
    qrm_pkg::t_mat_rsp        r_rsp, n_rsp;
    logic signed [8:0][15:0]  ent;
    logic signed [QW:0]       sv;
    logic                     en;

    assign en      = !r_v || i_ready;
    assign o_ready = en;
    assign o_valid = r_v;
    assign o_rsp   = r_rsp;

    always_comb begin
        sv = '0;
        for (int k = 0; k < 9; k++) begin
            sv = i_neg[k] ? -$signed({1'b0, i_q[k]}) : $signed({1'b0, i_q[k]});
            if (i_zero) begin
                ent[k] = (k % 4 == 0) ? ONE : 16'sd0;
            end else if (sv > 32767) begin
                ent[k] = 16'sd32767;
            end else if (sv < -32768) begin
                ent[k] = -16'sd32768;
            end else begin
                ent[k] = 16'(sv);
            end
        end
        n_rsp.m00 = ent[0];
        n_rsp.m01 = ent[1];
        n_rsp.m02 = ent[2];
        n_rsp.m10 = ent[3];
        n_rsp.m11 = ent[4];
        n_rsp.m12 = ent[5];
        n_rsp.m20 = ent[6];
        n_rsp.m21 = ent[7];
        n_rsp.m22 = ent[8];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (en) begin
            r_v <= i_valid;
        end
        if (en && i_valid) r_rsp <= n_rsp;
    end
endmodule

[design/quaternion_to_rotation_matrix_top.sv]
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_top
// Normalized 3x3 rotation matrix from an unnormalized quaternion.
//
//   channel   direction  handshake              payload
//   request   in         i_valid / o_ready      i_req (t_quat_req)
//   response  out        o_valid / i_ready      o_rsp (t_mat_rsp)
//
// One request per cycle is accepted while no stall has filled the stages; it
// passes FRAC_BITS + 1 division cells, one quotient bit each, in a chain.
// Every stage holds its own valid bit, so a stalled response only stops
// the stages behind it once they fill up; bubbles are squeezed out.
// Synchronous reset clears all valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix_top #(
    parameter int FRAC_BITS = qrm_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  qrm_pkg::t_quat_req i_req,
    output logic               o_valid,
    input  logic               i_ready,
    output qrm_pkg::t_mat_rsp  o_rsp
);
    localparam int DW = FRAC_BITS + 34;
    localparam int QW = FRAC_BITS + 1;

    logic [QW:0]                             c_v, c_r;
    logic [QW:0][qrm_pkg::NORM_W-1:0]        c_den;
    logic [QW:0]                             c_zero;
    logic [QW:0][8:0]                        c_neg;
    logic [QW:0][8:0][DW-1:0]                c_rem;
    logic [QW:0][8:0][QW-1:0]                c_q;

    qrm_front #(.FRAC_BITS(FRAC_BITS), .DW(DW)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_req(i_req),
        .o_valid(c_v[0]), .i_ready(c_r[0]),
        .o_den(c_den[0]), .o_zero(c_zero[0]), .o_neg(c_neg[0]), .o_rem(c_rem[0])
    );
    assign c_q[0] = '0;

    // Cell j settles quotient bit QW-1-j, most significant first.
    for (genvar j = 0; j < QW; j++) begin : g_cell
        qrm_cell #(.FRAC_BITS(FRAC_BITS), .DW(DW), .QW(QW), .BIT(QW-1-j)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_valid(c_v[j]), .o_ready(c_r[j]),
            .i_den(c_den[j]), .i_zero(c_zero[j]), .i_neg(c_neg[j]),
            .i_rem(c_rem[j]), .i_q(c_q[j]),
            .o_valid(c_v[j+1]), .i_ready(c_r[j+1]),
            .o_den(c_den[j+1]), .o_zero(c_zero[j+1]), .o_neg(c_neg[j+1]),
            .o_rem(c_rem[j+1]), .o_q(c_q[j+1])
        );
    end

    qrm_back #(.FRAC_BITS(FRAC_BITS), .QW(QW)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(c_v[QW]), .o_ready(c_r[QW]),
        .i_zero(c_zero[QW]), .i_neg(c_neg[QW]), .i_q(c_q[QW]),
        .o_valid(o_valid), .i_ready(i_ready), .o_rsp(o_rsp)
    );

    // The last cell's remainder and denominator are not needed downstream.
    logic unused_tail;
    assign unused_tail = ^{c_rem[QW], c_den[QW]};
endmodule

[design/qrm_checker.sv]
// ----------------------------------------------------------------------------
// qrm_checker
// Port-level checks for the quaternion to rotation matrix block.
// ----------------------------------------------------------------------------
module qrm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input qrm_pkg::t_mat_rsp  o_rsp
);
    // A stalled response must hold.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_rsp))
        else $error("response changed while stalled");

    // Nothing comes out the cycle after reset.
    a_rst: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_valid)
        else $error("response valid after reset");

    // With an empty output stage the whole chain can move.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("request blocked with empty output");

    // A diagonal entry never exceeds one in magnitude, whatever the input's length.
    a_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_rsp.m00 <= 16'sd16384 && o_rsp.m00 >= -16'sd16384 &&
                    o_rsp.m11 <= 16'sd16384 && o_rsp.m11 >= -16'sd16384 &&
                    o_rsp.m22 <= 16'sd16384 && o_rsp.m22 >= -16'sd16384)
        else $error("diagonal entry out of range");
endmodule

bind quaternion_to_rotation_matrix_top qrm_checker u_qrm_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_rsp(o_rsp)
);
